// File: hw/rtl/cie_pkg.sv
package cie_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Command codes as they arrive on the input channel.
  localparam logic [2:0] CMD_HALT = 3'd0;
  localparam logic [2:0] CMD_DP   = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_LS   = 3'd3;
  localparam logic [2:0] CMD_BR   = 3'd4;

  // Data processing opcodes.
  localparam logic [3:0] OPC_AND = 4'd0;
  localparam logic [3:0] OPC_EOR = 4'd1;
  localparam logic [3:0] OPC_SUB = 4'd2;
  localparam logic [3:0] OPC_RSB = 4'd3;
  localparam logic [3:0] OPC_ADD = 4'd4;
  localparam logic [3:0] OPC_TST = 4'd8;
  localparam logic [3:0] OPC_TEQ = 4'd9;
  localparam logic [3:0] OPC_CMP = 4'd10;
  localparam logic [3:0] OPC_ORR = 4'd12;
  localparam logic [3:0] OPC_MOV = 4'd13;

  // Condition codes.
  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_GE = 4'd10;
  localparam logic [3:0] COND_LT = 4'd11;
  localparam logic [3:0] COND_GT = 4'd12;
  localparam logic [3:0] COND_LE = 4'd13;
  localparam logic [3:0] COND_AL = 4'd14;

  // Shift types.
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;

  localparam logic [3:0] REG_PC = 4'd15;

  typedef enum logic [2:0] {
    CLS_HALT = 3'd0,
    CLS_DP   = 3'd1,
    CLS_MUL  = 3'd2,
    CLS_LS   = 3'd3,
    CLS_BR   = 3'd4,
    CLS_NONE = 3'd5
  } cls_e;

  typedef struct packed {
    cls_e        cls;
    logic [31:0] ins;
    logic [31:0] pc;
  } item_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SHIFT = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_MEM   = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  function automatic cls_e classify(logic [2:0] cmd);
    cls_e c;
    case (cmd)
      CMD_HALT: c = CLS_HALT;
      CMD_DP:   c = CLS_DP;
      CMD_MUL:  c = CLS_MUL;
      CMD_LS:   c = CLS_LS;
      CMD_BR:   c = CLS_BR;
      default:  c = CLS_NONE;
    endcase
    return c;
  endfunction

  function automatic logic cond_ok(logic [3:0] code, logic [3:0] flags);
    logic n, z, v, ok;
    n = flags[3];
    z = flags[2];
    v = flags[0];
    case (code)
      COND_EQ: ok = z;
      COND_NE: ok = !z;
      COND_GE: ok = (n == v);
      COND_LT: ok = (n != v);
      COND_GT: ok = !z && (n == v);
      COND_LE: ok = z || (n != v);
      COND_AL: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Returns {carry, value}.
  function automatic logic [32:0] rot_imm(logic [11:0] op);
    logic [4:0]  r;
    logic [31:0] x;
    logic [63:0] sh;
    logic [32:0] res;
    r  = {op[11:8], 1'b0};
    x  = {24'b0, op[7:0]};
    sh = {x, x} >> r;
    if (r == 5'd0) begin
      res = {1'b0, x};
    end else begin
      res = {sh[31], sh[31:0]};
    end
    return res;
  endfunction

  // Barrel shifter, returns {carry, value}.
  function automatic logic [32:0] shift_op(logic [31:0] v, logic [1:0] typ, logic [7:0] amt);
    logic [32:0] t;
    logic [63:0] sh;
    logic [32:0] res;
    logic        lt32, eq32;
    lt32 = (amt[7:5] == 3'd0);
    eq32 = (amt == 8'd32);
    t    = '0;
    sh   = '0;
    if (amt == 8'd0) begin
      res = {1'b0, v};
    end else begin
      case (typ)
        SH_LSL: begin
          t = {1'b0, v} << amt[4:0];
          if (lt32) res = t;
          else if (eq32) res = {v[0], 32'b0};
          else res = '0;
        end
        SH_LSR: begin
          t = {v, 1'b0} >> amt[4:0];
          if (lt32) res = {t[0], t[32:1]};
          else if (eq32) res = {v[31], 32'b0};
          else res = '0;
        end
        SH_ASR: begin
          t = $signed({v, 1'b0}) >>> amt[4:0];
          if (lt32) res = {t[0], t[32:1]};
          else res = {v[31], {32{v[31]}}};
        end
        default: begin
          sh = {v, v} >> amt[4:0];
          if (amt[4:0] == 5'd0) res = {v[31], v};
          else res = {sh[31], sh[31:0]};
        end
      endcase
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/cie_front.sv
module cie_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        command_i,
  input  logic [31:0]       instruction_i,
  input  logic [31:0]       pc_now_i,
  input  logic              q_full_i,
  input  logic              clear_busy_i,
  output logic              push_o,
  output cie_pkg::item_t    item_o
);

  // No transaction is taken while the queue is full or memory is being cleared.
  assign in_stall_o = q_full_i | clear_busy_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  assign item_o.cls = cie_pkg::classify(command_i);
  assign item_o.ins = instruction_i;
  assign item_o.pc  = pc_now_i;

endmodule

// File: hw/rtl/cie_queue.sv
module cie_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cie_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cie_pkg::item_t head_o
);

  localparam int unsigned PW = $clog2(cie_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(cie_pkg::QUEUE_DEPTH + 1);

  cie_pkg::item_t ent_q [cie_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CW'(cie_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: hw/rtl/cie_back.sv
module cie_back #(
  parameter int unsigned MEM_BYTES = cie_pkg::MEM_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  cie_pkg::item_t head_i,
  output logic           pop_o,
  output logic           clear_busy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           cond_passed_o,
  output logic           halt_seen_o,
  output logic           dest_written_o,
  output logic [3:0]     dest_index_o,
  output logic [31:0]    dest_value_o,
  output logic           base_written_o,
  output logic [3:0]     base_index_o,
  output logic [31:0]    base_value_o,
  output logic [3:0]     flags_now_o,
  output logic [31:0]    next_pc_o,
  output logic           mem_fault_o
);

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned RW   = AW - 2;
  localparam int unsigned ROWS = (MEM_BYTES + 3) / 4;
  localparam logic [31:0] ADDR_MAX = 32'(MEM_BYTES - 4);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  cie_pkg::state_e state_q, state_d;
  cie_pkg::cls_e   cls_q;
  logic [31:0]     ins_q, pc_q;

  // Register file: entry fifteen is never written, reads of it give the PC.
  logic [31:0] rf_mem [16];
  logic [15:0] rf_vld_q;
  logic [3:0]  ra, rb, rai_q, rbi_q;
  logic [31:0] rda_q, rdb_q, op_a, op_b;
  logic        rf_we;
  logic [3:0]  rf_widx;
  logic [31:0] rf_wdat;

  logic [32:0] op2_q, sh_res, ri_res;
  logic [31:0] prod_q, prod_c;
  logic [3:0]  flags_q;

  // Result being built for the current item.
  logic        r_pass_q, r_halt_q, r_dw_q, r_bw_q, r_fault_q;
  logic [3:0]  r_di_q, r_bi_q;
  logic [31:0] r_dv_q, r_bv_q, r_npc_q;
  logic        wr_en_q;
  logic [3:0]  wr_idx_q;
  logic [31:0] wr_val_q;

  logic [AW-1:0] addr_q;
  logic [31:0]   st_data_q;

  logic          clr_busy_q;
  logic [RW-1:0] clr_row_q;

  logic [RW-1:0] lane_row [4];
  logic [7:0]    lane_wd  [4];
  logic [3:0]    lane_we;
  logic [7:0]    lane_rd_q [4];
  logic [31:0]   ld_word;

  logic          out_vld_q;
  logic          out_load;

  // Execute step results.
  logic        ex_pass;
  logic [31:0] alu_res;
  logic        alu_c, alu_wr, alu_known;
  logic [32:0] sum;
  logic [31:0] mres, nb, ls_addr, br_off;
  logic        ls_fault;

  assign clear_busy_o = clr_busy_q;
  assign pop_o = (state_q == cie_pkg::ST_IDLE) && !q_empty_i && !clr_busy_q;
  assign out_load = (state_q == cie_pkg::ST_FIN) && (!out_vld_q || !out_stall_i);

  // ---------------- register file ----------------
  always_comb begin
    if (state_q == cie_pkg::ST_IDLE) begin
      ra = head_i.ins[3:0];
      rb = head_i.ins[11:8];
    end else begin
      ra = (cls_q == cie_pkg::CLS_MUL) ? ins_q[15:12] : ins_q[19:16];
      rb = ins_q[15:12];
    end
  end

  assign op_a = (rai_q == cie_pkg::REG_PC) ? pc_q : rda_q;
  assign op_b = (rbi_q == cie_pkg::REG_PC) ? pc_q : rdb_q;

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_widx] <= rf_wdat;
    rda_q <= rf_vld_q[ra] ? rf_mem[ra] : '0;
    rdb_q <= rf_vld_q[rb] ? rf_mem[rb] : '0;
    rai_q <= ra;
    rbi_q <= rb;
  end

  always_comb begin
    rf_we   = 1'b0;
    rf_widx = wr_idx_q;
    rf_wdat = wr_val_q;
    if (state_q == cie_pkg::ST_LOAD) begin
      rf_widx = ins_q[15:12];
      rf_wdat = ld_word;
      rf_we   = (ins_q[15:12] != cie_pkg::REG_PC);
    end else if (out_load) begin
      rf_we = wr_en_q && (wr_idx_q != cie_pkg::REG_PC);
    end
  end

  // ---------------- operand stage ----------------
  assign sh_res = cie_pkg::shift_op(op_a, ins_q[6:5],
                                    ins_q[4] ? op_b[7:0] : {3'b0, ins_q[11:7]});
  assign ri_res = cie_pkg::rot_imm(ins_q[11:0]);
  assign prod_c = op_a * op_b;

  // ---------------- execute stage ----------------
  assign ex_pass = cie_pkg::cond_ok(ins_q[31:28], flags_q) && (cls_q != cie_pkg::CLS_NONE);

  always_comb begin
    alu_res   = '0;
    alu_c     = op2_q[32];
    alu_wr    = 1'b1;
    alu_known = 1'b1;
    sum       = {1'b0, op_a} + {1'b0, op2_q[31:0]};
    case (ins_q[24:21])
      cie_pkg::OPC_AND: alu_res = op_a & op2_q[31:0];
      cie_pkg::OPC_EOR: alu_res = op_a ^ op2_q[31:0];
      cie_pkg::OPC_SUB: begin
        alu_res = op_a - op2_q[31:0];
        alu_c   = op_a >= op2_q[31:0];
      end
      cie_pkg::OPC_RSB: begin
        alu_res = op2_q[31:0] - op_a;
        alu_c   = op2_q[31:0] >= op_a;
      end
      cie_pkg::OPC_ADD: begin
        alu_res = sum[31:0];
        alu_c   = sum[32];
      end
      cie_pkg::OPC_TST: begin
        alu_res = op_a & op2_q[31:0];
        alu_wr  = 1'b0;
      end
      cie_pkg::OPC_TEQ: begin
        alu_res = op_a ^ op2_q[31:0];
        alu_wr  = 1'b0;
      end
      cie_pkg::OPC_CMP: begin
        alu_res = op_a - op2_q[31:0];
        alu_c   = op_a >= op2_q[31:0];
        alu_wr  = 1'b0;
      end
      cie_pkg::OPC_ORR: alu_res = op_a | op2_q[31:0];
      cie_pkg::OPC_MOV: alu_res = op2_q[31:0];
      default: begin
        alu_known = 1'b0;
        alu_wr    = 1'b0;
      end
    endcase
  end

  assign mres     = prod_q + (ins_q[21] ? op_a : 32'd0);
  assign nb       = ins_q[23] ? (op_a + op2_q[31:0]) : (op_a - op2_q[31:0]);
  assign ls_addr  = ins_q[24] ? nb : op_a;
  assign ls_fault = ls_addr > ADDR_MAX;
  assign br_off   = {{6{ins_q[23]}}, ins_q[23:0], 2'b00};

  // ---------------- byte-lane memory ----------------
  always_comb begin
    logic [1:0] k;
    for (int l = 0; l < 4; l++) begin
      k = 2'(l) - addr_q[1:0];
      if (clr_busy_q) begin
        lane_row[l] = clr_row_q;
        lane_wd[l]  = '0;
        lane_we[l]  = 1'b1;
      end else begin
        lane_row[l] = (2'(l) >= addr_q[1:0]) ? addr_q[AW-1:2] : (addr_q[AW-1:2] + 1'b1);
        lane_wd[l]  = st_data_q[8*k +: 8];
        lane_we[l]  = (state_q == cie_pkg::ST_MEM) && !ins_q[20];
      end
    end
  end

  for (genvar gl = 0; gl < 4; gl++) begin : g_lane
    logic [7:0] mem [ROWS];
    always_ff @(posedge clk_i) begin
      if (lane_we[gl]) mem[lane_row[gl]] <= lane_wd[gl];
      lane_rd_q[gl] <= mem[lane_row[gl]];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_word[8*k +: 8] = lane_rd_q[addr_q[1:0] + 2'(k)];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      cie_pkg::ST_IDLE:  if (pop_o) state_d = cie_pkg::ST_SHIFT;
      cie_pkg::ST_SHIFT: state_d = cie_pkg::ST_EXEC;
      cie_pkg::ST_EXEC: begin
        if (ex_pass && (cls_q == cie_pkg::CLS_LS) && !ls_fault) state_d = cie_pkg::ST_MEM;
        else state_d = cie_pkg::ST_FIN;
      end
      cie_pkg::ST_MEM:   state_d = ins_q[20] ? cie_pkg::ST_LOAD : cie_pkg::ST_FIN;
      cie_pkg::ST_LOAD:  state_d = cie_pkg::ST_FIN;
      cie_pkg::ST_FIN:   if (out_load) state_d = cie_pkg::ST_IDLE;
      default:           state_d = cie_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cie_pkg::ST_IDLE;
      flags_q    <= '0;
      rf_vld_q   <= '0;
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rf_we) rf_vld_q[rf_widx] <= 1'b1;
      if (clr_busy_q) begin
        clr_row_q <= clr_row_q + 1'b1;
        if (clr_row_q == LAST_ROW) clr_busy_q <= 1'b0;
      end
      if (state_q == cie_pkg::ST_EXEC && ex_pass) begin
        if (cls_q == cie_pkg::CLS_DP && alu_known && ins_q[20]) begin
          flags_q <= {alu_res[31], alu_res == '0, alu_c, flags_q[0]};
        end else if (cls_q == cie_pkg::CLS_MUL && ins_q[20]) begin
          flags_q <= {mres[31], mres == '0, flags_q[1:0]};
        end
      end
      if (out_load) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cls_q <= head_i.cls;
      ins_q <= head_i.ins;
      pc_q  <= head_i.pc;
    end
    if (state_q == cie_pkg::ST_SHIFT) begin
      if (cls_q == cie_pkg::CLS_DP) op2_q <= ins_q[25] ? ri_res : sh_res;
      else op2_q <= ins_q[25] ? sh_res : {21'b0, ins_q[11:0]};
      prod_q <= prod_c;
    end
    if (state_q == cie_pkg::ST_EXEC) begin
      r_pass_q  <= ex_pass;
      r_halt_q  <= (cls_q == cie_pkg::CLS_HALT);
      r_dw_q    <= 1'b0;
      r_di_q    <= '0;
      r_dv_q    <= '0;
      r_bw_q    <= 1'b0;
      r_bi_q    <= '0;
      r_bv_q    <= '0;
      r_npc_q   <= pc_q;
      r_fault_q <= 1'b0;
      wr_en_q   <= 1'b0;
      wr_idx_q  <= '0;
      wr_val_q  <= '0;
      addr_q    <= ls_addr[AW-1:0];
      st_data_q <= op_b;
      if (ex_pass) begin
        case (cls_q)
          cie_pkg::CLS_DP: begin
            if (alu_wr) begin
              r_dw_q   <= 1'b1;
              r_di_q   <= ins_q[15:12];
              r_dv_q   <= alu_res;
              wr_en_q  <= 1'b1;
              wr_idx_q <= ins_q[15:12];
              wr_val_q <= alu_res;
            end
          end
          cie_pkg::CLS_MUL: begin
            r_dw_q   <= 1'b1;
            r_di_q   <= ins_q[19:16];
            r_dv_q   <= mres;
            wr_en_q  <= 1'b1;
            wr_idx_q <= ins_q[19:16];
            wr_val_q <= mres;
          end
          cie_pkg::CLS_LS: begin
            if (ls_fault) begin
              r_fault_q <= 1'b1;
            end else if (!ins_q[24]) begin
              // Post-indexed: the base update lands after any load write.
              r_bw_q   <= 1'b1;
              r_bi_q   <= ins_q[19:16];
              r_bv_q   <= nb;
              wr_en_q  <= 1'b1;
              wr_idx_q <= ins_q[19:16];
              wr_val_q <= nb;
            end
          end
          cie_pkg::CLS_BR: r_npc_q <= pc_q + br_off;
          default: ;
        endcase
      end
    end
    if (state_q == cie_pkg::ST_LOAD) begin
      r_dw_q <= 1'b1;
      r_di_q <= ins_q[15:12];
      r_dv_q <= ld_word;
    end
    if (out_load) begin
      cond_passed_o  <= r_pass_q;
      halt_seen_o    <= r_halt_q;
      dest_written_o <= r_dw_q;
      dest_index_o   <= r_di_q;
      dest_value_o   <= r_dv_q;
      base_written_o <= r_bw_q;
      base_index_o   <= r_bi_q;
      base_value_o   <= r_bv_q;
      flags_now_o    <= flags_q;
      next_pc_o      <= r_npc_q;
      mem_fault_o    <= r_fault_q;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

// File: hw/rtl/conditional_instruction_execute_unit.sv
// Conditional execute stage for a small 32-bit load/store core. Each transaction carries a
// classified instruction and its PC; the front end takes it into a two-entry queue and the back
// end sequencer executes it against the register file, NZCV flags and a byte memory built from
// four byte-lane RAMs, producing one result transaction. Stores that reach memory add a
// memory access step in the back end and such loads add a load-write step after it; halt,
// branch, data processing, multiply and a transfer that fails its condition or faults add
// neither. The steps are two register-file read steps, an execute step, the registered
// memory access for transfers, and the result register. After reset the memory is cleared
// at one row of four bytes per cycle, during which no input transaction is accepted.
module conditional_instruction_execute_unit #(
  parameter int unsigned MEM_BYTES = cie_pkg::MEM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] instruction_i,
  input  logic [31:0] pc_now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        cond_passed_o,
  output logic        halt_seen_o,
  output logic        dest_written_o,
  output logic [3:0]  dest_index_o,
  output logic [31:0] dest_value_o,
  output logic        base_written_o,
  output logic [3:0]  base_index_o,
  output logic [31:0] base_value_o,
  output logic [3:0]  flags_now_o,
  output logic [31:0] next_pc_o,
  output logic        mem_fault_o
);

  logic           q_full, q_empty, push, pop, clear_busy;
  cie_pkg::item_t item, head;

  cie_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .instruction_i (instruction_i),
    .pc_now_i      (pc_now_i),
    .q_full_i      (q_full),
    .clear_busy_i  (clear_busy),
    .push_o        (push),
    .item_o        (item)
  );

  cie_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  cie_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .head_i         (head),
    .pop_o          (pop),
    .clear_busy_o   (clear_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cond_passed_o  (cond_passed_o),
    .halt_seen_o    (halt_seen_o),
    .dest_written_o (dest_written_o),
    .dest_index_o   (dest_index_o),
    .dest_value_o   (dest_value_o),
    .base_written_o (base_written_o),
    .base_index_o   (base_index_o),
    .base_value_o   (base_value_o),
    .flags_now_o    (flags_now_o),
    .next_pc_o      (next_pc_o),
    .mem_fault_o    (mem_fault_o)
  );

endmodule

// File: hw/rtl/cie_checker.sv
module cie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        cond_passed_o,
  input logic        halt_seen_o,
  input logic        dest_written_o,
  input logic [3:0]  dest_index_o,
  input logic [31:0] dest_value_o,
  input logic        base_written_o,
  input logic [3:0]  base_index_o,
  input logic [31:0] base_value_o,
  input logic        mem_fault_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dest_value_o) && $stable(base_value_o))
    else $error("stalled result transaction changed");

  a_fail_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cond_passed_o |-> !dest_written_o && !base_written_o && !mem_fault_o)
    else $error("failed condition produced an effect");

  a_halt_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halt_seen_o |-> !dest_written_o && !base_written_o && !mem_fault_o)
    else $error("halt produced a write");

  a_fault_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mem_fault_o |-> !dest_written_o && !base_written_o)
    else $error("faulting transfer wrote a register");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !base_written_o && !dest_written_o |->
      base_index_o == 4'd0 && base_value_o == 32'd0 && dest_index_o == 4'd0)
    else $error("unwritten register fields are not zero");

endmodule

bind conditional_instruction_execute_unit cie_checker u_cie_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MEMB       = cie_pkg::MEM_BYTES_DEF;
  localparam int          N_RANDOM   = 630;
  localparam int          IDLE_LIMIT = MEMB / 4 + 40000;

  // Encodings outside the listed ones, used to probe the no-effect paths.
  localparam logic [3:0] OPC_UNLISTED = 4'd5;
  localparam logic [2:0] CMD_SPARE    = 3'd5;
  localparam logic [2:0] CMD_TOP      = 3'd7;

  typedef struct packed {
    logic        passed;
    logic        halt;
    logic        dw;
    logic [3:0]  di;
    logic [31:0] dv;
    logic        bw;
    logic [3:0]  bi;
    logic [31:0] bv;
    logic [3:0]  flags;
    logic [31:0] npc;
    logic        fault;
  } outcome_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] ins;
    logic [31:0] pc;
    logic        known;   // expected outcome typed in below
    outcome_t    res;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [2:0]  command_i;
  logic [31:0] instruction_i, pc_now_i;
  logic out_valid_o, out_stall_i;
  logic cond_passed_o, halt_seen_o, dest_written_o, base_written_o, mem_fault_o;
  logic [3:0]  dest_index_o, base_index_o, flags_now_o;
  logic [31:0] dest_value_o, base_value_o, next_pc_o;

  conditional_instruction_execute_unit dut (.*);

  // Predictor state.
  logic [31:0] regs_m [15];
  logic [3:0]  flags_m;
  logic [7:0]  mem_m [MEMB];

  outcome_t expected_q[$];
  int  errors;
  int  idle_cycles;
  bit  hold_off;
  bit  done_sending;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] reg_rd(logic [3:0] i, logic [31:0] pc);
    return (i == cie_pkg::REG_PC) ? pc : regs_m[i];
  endfunction

  function automatic void reg_wr(logic [3:0] i, logic [31:0] v);
    if (i != cie_pkg::REG_PC) regs_m[i] = v;
  endfunction

  function automatic logic cond_holds(logic [3:0] c);
    logic n, z, v;
    n = flags_m[3];
    z = flags_m[2];
    v = flags_m[0];
    case (c)
      cie_pkg::COND_EQ: return z;
      cie_pkg::COND_NE: return !z;
      cie_pkg::COND_GE: return n == v;
      cie_pkg::COND_LT: return n != v;
      cie_pkg::COND_GT: return !z && n == v;
      cie_pkg::COND_LE: return z || n != v;
      cie_pkg::COND_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] barrel(logic [11:0] op, logic [31:0] pc, output logic cy);
    logic [31:0] v, rs;
    logic [7:0]  amt;
    logic [4:0]  r;
    v   = reg_rd(op[3:0], pc);
    rs  = reg_rd(op[11:8], pc);
    amt = op[4] ? rs[7:0] : {3'b0, op[11:7]};
    cy  = 1'b0;
    if (amt == 0) return v;
    case (op[6:5])
      cie_pkg::SH_LSL: begin
        if (amt < 32) begin cy = v[32 - amt]; return v << amt; end
        cy = (amt == 32) ? v[0] : 1'b0;
        return '0;
      end
      cie_pkg::SH_LSR: begin
        if (amt < 32) begin cy = v[amt - 1]; return v >> amt; end
        cy = (amt == 32) ? v[31] : 1'b0;
        return '0;
      end
      cie_pkg::SH_ASR: begin
        if (amt < 32) begin cy = v[amt - 1]; return $unsigned($signed(v) >>> amt); end
        cy = v[31];
        return {32{v[31]}};
      end
      default: begin
        r = amt[4:0];
        if (r == 0) begin cy = v[31]; return v; end
        cy = v[r - 1];
        return (v >> r) | (v << (32 - r));
      end
    endcase
  endfunction

  function automatic outcome_t execute_instr(logic [2:0] cmd, logic [31:0] ins, logic [31:0] pc);
    outcome_t o;
    logic [31:0] rn, op2, res, off, base, nb, addr, w;
    logic [4:0]  rot;
    logic        c, wr, known;
    o = '{default: '0};
    o.npc  = pc;
    o.halt = (cmd == cie_pkg::CMD_HALT);
    if (cond_holds(ins[31:28]) && cmd <= cie_pkg::CMD_BR) begin
      o.passed = 1'b1;
      case (cmd)
        cie_pkg::CMD_DP: begin
          rn = reg_rd(ins[19:16], pc);
          c = 1'b0;
          if (ins[25]) begin
            rot = {ins[11:8], 1'b0};
            op2 = {24'b0, ins[7:0]};
            if (rot != 0) begin
              op2 = (op2 >> rot) | (op2 << (32 - rot));
              c = op2[31];
            end
          end else begin
            op2 = barrel(ins[11:0], pc, c);
          end
          wr = 1'b1;
          known = 1'b1;
          res = '0;
          case (ins[24:21])
            cie_pkg::OPC_AND: res = rn & op2;
            cie_pkg::OPC_EOR: res = rn ^ op2;
            cie_pkg::OPC_SUB: begin res = rn - op2; c = rn >= op2; end
            cie_pkg::OPC_RSB: begin res = op2 - rn; c = op2 >= rn; end
            cie_pkg::OPC_ADD: begin res = rn + op2; c = res < rn; end
            cie_pkg::OPC_TST: begin res = rn & op2; wr = 1'b0; end
            cie_pkg::OPC_TEQ: begin res = rn ^ op2; wr = 1'b0; end
            cie_pkg::OPC_CMP: begin res = rn - op2; c = rn >= op2; wr = 1'b0; end
            cie_pkg::OPC_ORR: res = rn | op2;
            cie_pkg::OPC_MOV: res = op2;
            default: begin known = 1'b0; wr = 1'b0; end
          endcase
          if (wr) begin
            o.dw = 1'b1; o.di = ins[15:12]; o.dv = res;
            reg_wr(ins[15:12], res);
          end
          if (known && ins[20]) flags_m = {res[31], res == 0, c, flags_m[0]};
        end
        cie_pkg::CMD_MUL: begin
          res = reg_rd(ins[3:0], pc) * reg_rd(ins[11:8], pc);
          if (ins[21]) res += reg_rd(ins[15:12], pc);
          o.dw = 1'b1; o.di = ins[19:16]; o.dv = res;
          reg_wr(ins[19:16], res);
          if (ins[20]) flags_m = {res[31], res == 0, flags_m[1:0]};
        end
        cie_pkg::CMD_LS: begin
          off  = ins[25] ? barrel(ins[11:0], pc, c) : {20'b0, ins[11:0]};
          base = reg_rd(ins[19:16], pc);
          nb   = ins[23] ? base + off : base - off;
          addr = ins[24] ? nb : base;
          if (addr > MEMB - 4) begin
            o.fault = 1'b1;
          end else begin
            if (ins[20]) begin
              w = {mem_m[addr + 3], mem_m[addr + 2], mem_m[addr + 1], mem_m[addr]};
              o.dw = 1'b1; o.di = ins[15:12]; o.dv = w;
              reg_wr(ins[15:12], w);
            end else begin
              w = reg_rd(ins[15:12], pc);
              {mem_m[addr + 3], mem_m[addr + 2], mem_m[addr + 1], mem_m[addr]} = w;
            end
            if (!ins[24]) begin
              o.bw = 1'b1; o.bi = ins[19:16]; o.bv = nb;
              reg_wr(ins[19:16], nb);
            end
          end
        end
        cie_pkg::CMD_BR: begin
          off = {{6{ins[23]}}, ins[23:0], 2'b00};
          o.npc = pc + off;
        end
        default: ;
      endcase
    end
    o.flags = flags_m;
    return o;
  endfunction

  task automatic send(logic [2:0] cmd, logic [31:0] ins, logic [31:0] pc);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    instruction_i <= ins;
    pc_now_i      <= pc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Random instruction biased toward useful forms: mostly AL, small addresses.
  function automatic logic [31:0] rand_ins(logic [2:0] cmd);
    logic [31:0] ins;
    logic [3:0]  cc;
    int k;
    ins = $urandom;
    k = $urandom_range(0, 9);
    cc = (k < 6) ? cie_pkg::COND_AL
                 : (k < 9 ? 4'($urandom_range(0, 15)) : 4'($urandom_range(10, 13)));
    ins[31:28] = cc;
    if (cmd == cie_pkg::CMD_LS && $urandom_range(0, 4) != 0) begin
      ins[19:16] = 4'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) begin
        ins[25] = 1'b0;
        ins[11:0] = 12'($urandom_range(0, 255)) & 12'hffc;
      end
    end
    if (cmd == cie_pkg::CMD_DP && $urandom_range(0, 3) == 0) ins[24:21] = cie_pkg::OPC_MOV;
    return ins;
  endfunction

  row_t rows [$];

  function automatic row_t mk(logic [2:0] cmd, logic [31:0] ins, logic [31:0] pc);
    row_t r;
    r.cmd = cmd; r.ins = ins; r.pc = pc; r.known = 1'b0;
    r.res = '{default: '0};
    return r;
  endfunction

  initial begin
    row_t r;
    logic [2:0] cmd;
    outcome_t o;
    for (int i = 0; i < 15; i++) regs_m[i] = '0;
    flags_m = '0;
    for (int i = 0; i < MEMB; i++) mem_m[i] = '0;
    errors = 0;
    hold_off = 1'b0;
    done_sending = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = cie_pkg::CMD_HALT;
    instruction_i = '0;
    pc_now_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Halt right after reset: only the pass and halt flags, next PC unchanged.
    r = mk(cie_pkg::CMD_HALT, {cie_pkg::COND_AL, 28'h0}, 32'h8);
    r.known = 1'b1;
    r.res = '{passed: 1'b1, halt: 1'b1, npc: 32'h8, default: '0};
    rows.push_back(r);
    // Failing condition code with flags zero: NE holds, EQ fails.
    r = mk(cie_pkg::CMD_DP, {cie_pkg::COND_EQ, 28'h3A00_0FF}, 32'hC);
    r.known = 1'b1;
    r.res = '{npc: 32'hC, default: '0};
    rows.push_back(r);
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_AL, 3'b001, cie_pkg::OPC_MOV, 1'b1, 4'h0, 4'h1, 12'h0FF},
                      32'h10));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_AL, 3'b001, cie_pkg::OPC_MOV, 1'b1, 4'h0, 4'h2, 12'h4FF},
                      32'h14));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_AL, 3'b001, cie_pkg::OPC_MOV, 1'b1, 4'h1, 4'h3, 12'h001},
                      32'h18));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_AL, 3'b001, cie_pkg::OPC_SUB, 1'b1, 4'h1, 4'h4, 12'h001},
                      32'h1C));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_AL, 3'b001, cie_pkg::OPC_RSB, 1'b1, 4'h2, 4'h5, 12'h001},
                      32'h20));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_AL, 3'b001, cie_pkg::OPC_ADD, 1'b1, 4'h2, 4'h6, 12'h002},
                      32'h24));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_GE, 3'b001, cie_pkg::OPC_CMP, 1'b1, 4'h1, 4'h0, 12'h001},
                      32'h28));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_LT, 3'b001, cie_pkg::OPC_TST, 1'b1, 4'h2, 4'h0, 12'h002},
                      32'h2C));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_GT, 3'b001, cie_pkg::OPC_TEQ, 1'b1, 4'h5, 4'h0, 12'h005},
                      32'h30));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_LE, 3'b000, cie_pkg::OPC_ORR, 1'b1, 4'hF, 4'h7, 12'h031},
                      32'h34));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_NE, 3'b000, cie_pkg::OPC_EOR, 1'b1, 4'h7, 4'hF, 12'h7D2},
                      32'h38));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_AL, 3'b001, OPC_UNLISTED, 1'b1, 4'h1, 4'h8, 12'h002},
                      32'h3C));
    rows.push_back(mk(cie_pkg::CMD_DP,
                      {cie_pkg::COND_AL, 3'b000, cie_pkg::OPC_MOV, 1'b1, 4'h0, 4'h9, 12'h671},
                      32'h40));
    rows.push_back(mk(cie_pkg::CMD_MUL,
                      {cie_pkg::COND_AL, 6'b000000, 1'b1, 1'b1, 4'hA, 4'h5, 4'h2, 4'h9, 4'h6},
                      32'h44));
    rows.push_back(mk(cie_pkg::CMD_LS,
                      {cie_pkg::COND_AL, 4'b0101, 1'b1, 2'b00, 1'b0, 4'h0, 4'h2, 12'h010},
                      32'h48));
    rows.push_back(mk(cie_pkg::CMD_LS,
                      {cie_pkg::COND_AL, 4'b0100, 1'b1, 2'b00, 1'b1, 4'h0, 4'hB, 12'h010},
                      32'h4C));
    rows.push_back(mk(cie_pkg::CMD_LS,
                      {cie_pkg::COND_AL, 4'b0100, 1'b1, 2'b00, 1'b1, 4'hF, 4'hC, 12'h000},
                      32'hFFFC));
    rows.push_back(mk(cie_pkg::CMD_LS,
                      {cie_pkg::COND_AL, 4'b0101, 1'b1, 2'b00, 1'b1, 4'hF, 4'hC, 12'h000},
                      32'hFFFF_FFF0));
    rows.push_back(mk(cie_pkg::CMD_LS,
                      {cie_pkg::COND_AL, 4'b0100, 1'b1, 2'b00, 1'b1, 4'h0, 4'h0, 12'h004},
                      32'h50));
    rows.push_back(mk(cie_pkg::CMD_BR, {cie_pkg::COND_AL, 4'b1010, 24'h800000}, 32'hFFFF_FFFF));
    rows.push_back(mk(cie_pkg::CMD_BR, {cie_pkg::COND_AL, 4'b1010, 24'h7FFFFF}, 32'h0));
    rows.push_back(mk(CMD_TOP, {cie_pkg::COND_AL, 28'hFFFFFFF}, 32'h5C));
    rows.push_back(mk(CMD_SPARE, 32'h0, 32'h60));

    foreach (rows[i]) begin
      o = execute_instr(rows[i].cmd, rows[i].ins, rows[i].pc);
      if (rows[i].known) expected_q.push_back(rows[i].res);
      else expected_q.push_back(o);
      send(rows[i].cmd, rows[i].ins, rows[i].pc);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_off = 1'b1;
      cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
      r = mk(cmd, rand_ins(cmd), $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096));
      expected_q.push_back(execute_instr(r.cmd, r.ins, r.pc));
      send(r.cmd, r.ins, r.pc);
    end
    in_valid_i <= 1'b0;
    done_sending = 1'b1;
  end

  // Output side: random stalls plus one long hold-off while the sender keeps going.
  initial begin
    int gap;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
      end
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      out_stall_i <= (gap > 0);
      repeat (gap > 0 ? gap : 1) @(posedge clk_i);
      if (gap > 0) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t e, a;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      a = '{passed: cond_passed_o, halt: halt_seen_o, dw: dest_written_o, di: dest_index_o,
            dv: dest_value_o, bw: base_written_o, bi: base_index_o, bv: base_value_o,
            flags: flags_now_o, npc: next_pc_o, fault: mem_fault_o};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction");
      end else begin
        e = expected_q.pop_front();
        if (a !== e) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp p%b h%b d%b/%0d/%h b%b/%0d/%h f%h pc%h m%b",
                     e.passed, e.halt, e.dw, e.di, e.dv, e.bw, e.bi, e.bv, e.flags, e.npc,
                     e.fault);
            $display("          got p%b h%b d%b/%0d/%h b%b/%0d/%h f%h pc%h m%b",
                     a.passed, a.halt, a.dw, a.di, a.dv, a.bw, a.bi, a.bv, a.flags, a.npc,
                     a.fault);
          end
        end
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
      if (done_sending && expected_q.size() == 0) begin
        repeat (20) @(posedge clk_i);
        if (errors == 0 && expected_q.size() == 0) begin
          $display("testbench: clean");
        end else begin
          $display("testbench: errors");
        end
        $finish;
      end
    end
  end

endmodule
